// File: hw/rtl/sqd_pkg.sv
// Package for the shortest queue dispatcher: field widths, defaults,
// controller states and the command/status words between controller and datapath.
// No dependencies.
package sqd_pkg;

   // Field widths, fixed by the word format
   localparam int ARRIVAL_W = 32;
   localparam int SERVICE_W = 16;
   localparam int PAYMENT_W = 24;
   localparam int ACTIVE_W  = 4;
   localparam int SERVER_W  = 3;
   localparam int TIME_W    = 32;
   localparam int COUNT_W   = 32;
   localparam int EARN_W    = 40;

   // Default sizing
   localparam int MAX_SERVERS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 16;

   // Active server count after reset
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_DECIDE,
      ST_COMMIT
   } sqd_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;          // latch the request word, restart the scan
      logic rd_issue;      // read the queued finish time under the scan pointer
      logic step_entry;    // entry expired: advance to the next one
      logic close_server;  // record drop count, update best, move to next server
      logic sel_best;      // lane select follows the chosen server
      logic calc;          // compute the finish time of the job
      logic commit;        // apply drops, push the job, load the response word
      logic reject_out;    // load a reject response word
   } sqd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic entry_pending; // scan pointer still inside the queue
      logic entry_expired; // entry read is at or before the arrival
      logic last_server;   // scan sits on the last active server
      logic reject;        // every active queue is full
      logic out_free;      // response register can take a new word
   } sqd_status_type;

endpackage

// File: hw/rtl/sqd_req_if.sv
// Request channel: one job word with valid/ready handshake.
// Depends on sqd_pkg for field widths.
interface sqd_req_if;
   logic                           valid;
   logic                           ready;
   logic [sqd_pkg::ARRIVAL_W-1:0]  arrival_time;
   logic [sqd_pkg::SERVICE_W-1:0]  service_time;
   logic [sqd_pkg::PAYMENT_W-1:0]  payment_cents;

   modport source (output valid, arrival_time, service_time, payment_cents, input ready);
   modport sink   (input valid, arrival_time, service_time, payment_cents, output ready);
endinterface

// File: hw/rtl/sqd_rsp_if.sv
// Response channel: one dispatch result word with valid/ready handshake.
// Depends on sqd_pkg for field widths.
interface sqd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sqd_pkg::SERVER_W-1:0]  assigned_server;
   logic                          rejected;
   logic [sqd_pkg::TIME_W-1:0]    finish_time;
   logic [sqd_pkg::COUNT_W-1:0]   server_job_count;
   logic [sqd_pkg::EARN_W-1:0]    server_earnings_cents;
   logic [sqd_pkg::TIME_W-1:0]    latest_finish;

   modport source (output valid, assigned_server, rejected, finish_time, server_job_count,
                   server_earnings_cents, latest_finish, input ready);
   modport sink   (input valid, assigned_server, rejected, finish_time, server_job_count,
                   server_earnings_cents, latest_finish, output ready);
endinterface

// File: hw/rtl/sqd_csr_if.sv
// Configuration write channel: active server count with valid/ready handshake.
// Depends on sqd_pkg for the register width.
interface sqd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sqd_pkg::ACTIVE_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/sqd_ctrl.sv
// Dispatcher controller: state machine that sequences accept, queue scan,
// decision and commit. Depends on sqd_pkg for states, command and status types.
module sqd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sqd_pkg::sqd_status_type status,
   output sqd_pkg::sqd_cmd_type    cmd
);

   sqd_pkg::sqd_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sqd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sqd_pkg::ST_IDLE: begin
            if (req_valid) state_in = sqd_pkg::ST_PROBE;
         end
         sqd_pkg::ST_PROBE: begin
            if (status.entry_pending) begin
               state_in = sqd_pkg::ST_CHECK;
            end else if (status.last_server) begin
               state_in = sqd_pkg::ST_DECIDE;
            end
         end
         sqd_pkg::ST_CHECK: begin
            if (status.entry_expired) begin
               state_in = sqd_pkg::ST_PROBE;
            end else if (status.last_server) begin
               state_in = sqd_pkg::ST_DECIDE;
            end else begin
               state_in = sqd_pkg::ST_PROBE;
            end
         end
         sqd_pkg::ST_DECIDE: begin
            if (!status.reject) begin
               state_in = sqd_pkg::ST_COMMIT;
            end else if (status.out_free) begin
               state_in = sqd_pkg::ST_IDLE;
            end
         end
         sqd_pkg::ST_COMMIT: begin
            if (status.out_free) state_in = sqd_pkg::ST_IDLE;
         end
         default: state_in = sqd_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sqd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         sqd_pkg::ST_PROBE: begin
            cmd.rd_issue     = status.entry_pending;
            cmd.close_server = !status.entry_pending;
         end
         sqd_pkg::ST_CHECK: begin
            cmd.step_entry   = status.entry_expired;
            cmd.close_server = !status.entry_expired;
         end
         sqd_pkg::ST_DECIDE: begin
            cmd.sel_best   = 1'b1;
            cmd.calc       = !status.reject;
            cmd.reject_out = status.reject && status.out_free;
         end
         sqd_pkg::ST_COMMIT: begin
            cmd.sel_best = 1'b1;
            cmd.commit   = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: hw/rtl/sqd_datapath.sv
// Dispatcher datapath: per-server lanes, finish time memory, scan counters,
// finish time arithmetic and the response register. Depends on sqd_pkg.
module sqd_datapath #(
   parameter int MAX_SERVERS = sqd_pkg::MAX_SERVERS_DEF,
   parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sqd_pkg::sqd_cmd_type           cmd,
   output sqd_pkg::sqd_status_type        status,
   input  logic [sqd_pkg::ARRIVAL_W-1:0]  req_arrival_time,
   input  logic [sqd_pkg::SERVICE_W-1:0]  req_service_time,
   input  logic [sqd_pkg::PAYMENT_W-1:0]  req_payment_cents,
   input  logic                           csr_write,
   input  logic [sqd_pkg::ACTIVE_W-1:0]   csr_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [sqd_pkg::SERVER_W-1:0]   rsp_assigned_server,
   output logic                           rsp_rejected,
   output logic [sqd_pkg::TIME_W-1:0]     rsp_finish_time,
   output logic [sqd_pkg::COUNT_W-1:0]    rsp_server_job_count,
   output logic [sqd_pkg::EARN_W-1:0]     rsp_server_earnings_cents,
   output logic [sqd_pkg::TIME_W-1:0]     rsp_latest_finish
);

   localparam int SW        = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int OW        = $clog2(QUEUE_DEPTH + 1);
   localparam int HW        = $clog2(QUEUE_DEPTH);
   localparam int MEM_DEPTH = MAX_SERVERS * QUEUE_DEPTH;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int TW        = sqd_pkg::TIME_W;
   localparam int EW        = sqd_pkg::EARN_W;
   localparam int CW        = sqd_pkg::COUNT_W;

   localparam logic [HW:0] QD_POS  = (HW + 1)'(QUEUE_DEPTH);
   localparam logic [OW-1:0] QD_OCC = OW'(QUEUE_DEPTH);
   localparam logic [5:0]  MAX_CNT = 6'(MAX_SERVERS);

   // Fold a position below twice the depth back into the queue
   function automatic logic [HW-1:0] wrap_pos(input logic [HW:0] pos);
      logic [HW:0] diff;
      diff = pos - QD_POS;
      return (pos >= QD_POS) ? diff[HW-1:0] : pos[HW-1:0];
   endfunction

   // Request word and configuration
   logic [sqd_pkg::ARRIVAL_W-1:0] arrival_ff;
   logic [sqd_pkg::SERVICE_W-1:0] service_ff;
   logic [sqd_pkg::PAYMENT_W-1:0] payment_ff;
   logic [sqd_pkg::ACTIVE_W-1:0]  active_ff;

   // Scan state
   logic [SW-1:0] srv_ff;
   logic [OW-1:0] cnt_ff;
   logic [SW-1:0] best_ff;
   logic [OW-1:0] best_len_ff;
   logic [OW-1:0] drop_ff [MAX_SERVERS];
   logic [TW-1:0] rdata_ff;
   logic [TW-1:0] fin_ff;

   // Per-server lanes
   logic [HW-1:0] head_ff [MAX_SERVERS];
   logic [OW-1:0] occ_ff  [MAX_SERVERS];
   logic [TW-1:0] last_ff [MAX_SERVERS];
   logic [CW-1:0] jobs_ff [MAX_SERVERS];
   logic [EW-1:0] earn_ff [MAX_SERVERS];
   logic [TW-1:0] latest_ff;

   // Queued finish times, one circular queue per server
   logic [TW-1:0] mem [MEM_DEPTH];

   // Response register
   logic                          rsp_valid_ff;
   logic [sqd_pkg::SERVER_W-1:0]  rsp_server_ff;
   logic                          rsp_rejected_ff;
   logic [TW-1:0]                 rsp_finish_ff;
   logic [CW-1:0]                 rsp_jobs_ff;
   logic [EW-1:0]                 rsp_earn_ff;
   logic [TW-1:0]                 rsp_latest_ff;

   // Combinational helpers
   logic [5:0]    act_ext;
   logic [5:0]    last_cnt;
   logic [SW-1:0] n_last;
   logic [SW-1:0] sel;
   logic [HW-1:0] head_sel;
   logic [OW-1:0] occ_sel;
   logic [OW-1:0] drop_sel;
   logic [TW-1:0] last_sel;
   logic [CW-1:0] jobs_sel;
   logic [EW-1:0] earn_sel;
   logic [OW-1:0] len;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [HW-1:0] head_new_sel;
   logic [OW-1:0] occ_new_sel;
   logic [TW-1:0] start;
   logic [TW:0]   fin_sum;
   logic [TW-1:0] fin_calc;
   logic [CW-1:0] jobs_new;
   logic [EW:0]   earn_sum;
   logic [EW-1:0] earn_new;
   logic [TW-1:0] latest_new;
   logic          out_free;

   // Clamp the active count to 1..MAX_SERVERS, as a last index
   assign act_ext = {2'b00, active_ff};
   always_comb begin
      priority if (act_ext == 6'd0) begin
         last_cnt = 6'd0;
      end else if (act_ext > MAX_CNT) begin
         last_cnt = MAX_CNT - 6'd1;
      end else begin
         last_cnt = act_ext - 6'd1;
      end
   end
   assign n_last = SW'(last_cnt);

   // Select one lane: scan server or chosen server
   assign sel      = cmd.sel_best ? best_ff : srv_ff;
   assign head_sel = head_ff[sel];
   assign occ_sel  = occ_ff[sel];
   assign drop_sel = drop_ff[sel];
   assign last_sel = last_ff[sel];
   assign jobs_sel = jobs_ff[sel];
   assign earn_sel = earn_ff[sel];

   // Scan address and remaining length
   assign rd_addr = AW'(srv_ff) * AW'(QUEUE_DEPTH)
                  + AW'(wrap_pos({1'b0, head_sel} + (HW + 1)'(cnt_ff)));
   assign len     = occ_sel - cnt_ff;

   // Push address after the drops of the chosen server
   assign head_new_sel = wrap_pos({1'b0, head_sel} + (HW + 1)'(drop_sel));
   assign occ_new_sel  = occ_sel - drop_sel;
   assign wr_addr = AW'(best_ff) * AW'(QUEUE_DEPTH)
                  + AW'(wrap_pos({1'b0, head_new_sel} + (HW + 1)'(occ_new_sel)));

   // Finish time, saturating
   assign start    = (last_sel > arrival_ff) ? last_sel : arrival_ff;
   assign fin_sum  = {1'b0, start} + (TW + 1)'(service_ff);
   assign fin_calc = fin_sum[TW] ? {TW{1'b1}} : fin_sum[TW-1:0];

   // Totals of the chosen server, saturating
   assign jobs_new   = (jobs_sel == {CW{1'b1}}) ? jobs_sel : jobs_sel + CW'(1);
   assign earn_sum   = {1'b0, earn_sel} + (EW + 1)'(payment_ff);
   assign earn_new   = earn_sum[EW] ? {EW{1'b1}} : earn_sum[EW-1:0];
   assign latest_new = (fin_ff > latest_ff) ? fin_ff : latest_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Status to the controller
   assign status.entry_pending = cnt_ff < occ_sel;
   assign status.entry_expired = rdata_ff <= arrival_ff;
   assign status.last_server   = srv_ff == n_last;
   assign status.reject        = best_len_ff >= QD_OCC;
   assign status.out_free      = out_free;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= sqd_pkg::ACTIVE_RESET;
      end else if (csr_write) begin
         active_ff <= csr_data;
      end
   end

   // Latch the request word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         arrival_ff <= req_arrival_time;
         service_ff <= req_service_time;
         payment_ff <= req_payment_cents;
      end
   end

   // Scan counters and best server tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         srv_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.load) begin
         srv_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.step_entry) begin
         cnt_ff <= cnt_ff + OW'(1);
      end else if (cmd.close_server) begin
         srv_ff <= srv_ff + SW'(1);
         cnt_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.close_server) begin
         drop_ff[srv_ff] <= cnt_ff;
         if (srv_ff == '0 || len < best_len_ff) begin
            best_ff     <= srv_ff;
            best_len_ff <= len;
         end
      end
      if (cmd.calc) begin
         fin_ff <= fin_calc;
      end
   end

   // Memory: read under the scan pointer, push on commit
   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rdata_ff <= mem[rd_addr];
      end
      if (cmd.commit) begin
         mem[wr_addr] <= fin_ff;
      end
   end

   // Lanes: apply drops on all active servers, push on the chosen one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            head_ff[i] <= '0;
            occ_ff[i]  <= '0;
            last_ff[i] <= '0;
            jobs_ff[i] <= '0;
            earn_ff[i] <= '0;
         end
         latest_ff <= '0;
      end else if (cmd.commit) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            if (SW'(i) <= n_last) begin
               head_ff[i] <= wrap_pos({1'b0, head_ff[i]} + (HW + 1)'(drop_ff[i]));
               occ_ff[i]  <= occ_ff[i] - drop_ff[i]
                           + {{(OW - 1){1'b0}}, (SW'(i) == best_ff)};
            end
            if (SW'(i) == best_ff) begin
               last_ff[i] <= fin_ff;
               jobs_ff[i] <= jobs_new;
               earn_ff[i] <= earn_new;
            end
         end
         latest_ff <= latest_new;
      end
   end

   // Response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit || cmd.reject_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_server_ff   <= sqd_pkg::SERVER_W'(best_ff);
         rsp_rejected_ff <= 1'b0;
         rsp_finish_ff   <= fin_ff;
         rsp_jobs_ff     <= jobs_new;
         rsp_earn_ff     <= earn_new;
         rsp_latest_ff   <= latest_new;
      end else if (cmd.reject_out) begin
         rsp_server_ff   <= '0;
         rsp_rejected_ff <= 1'b1;
         rsp_finish_ff   <= '0;
         rsp_jobs_ff     <= '0;
         rsp_earn_ff     <= '0;
         rsp_latest_ff   <= latest_ff;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_assigned_server       = rsp_server_ff;
   assign rsp_rejected              = rsp_rejected_ff;
   assign rsp_finish_time           = rsp_finish_ff;
   assign rsp_server_job_count      = rsp_jobs_ff;
   assign rsp_server_earnings_cents = rsp_earn_ff;
   assign rsp_latest_finish         = rsp_latest_ff;

endmodule

// File: hw/rtl/shortest_queue_dispatcher_unit.sv
// Throughput: one job at a time; the next job is accepted once the controller is back in
//   idle after the previous one's response is loaded. The scan of queued finish times goes
//   through the single read port of the finish time memory.
// Reset: synchronous; clears queues, totals and control; memory contents are not cleared.
module shortest_queue_dispatcher_unit #(
   parameter int MAX_SERVERS = sqd_pkg::MAX_SERVERS_DEF,
   parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sqd_req_if.sink     req_port,
   sqd_rsp_if.source   rsp_port,
   sqd_csr_if.sink     csr_port
);

   sqd_pkg::sqd_cmd_type    cmd;
   sqd_pkg::sqd_status_type status;

   // Configuration word is always taken
   assign csr_port.ready = 1'b1;

   // Sequencer
   sqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Lanes, memory and response register
   sqd_datapath #(
      .MAX_SERVERS (MAX_SERVERS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .req_arrival_time          (req_port.arrival_time),
      .req_service_time          (req_port.service_time),
      .req_payment_cents         (req_port.payment_cents),
      .csr_write                 (csr_port.valid),
      .csr_data                  (csr_port.data),
      .rsp_ready                 (rsp_port.ready),
      .rsp_valid                 (rsp_port.valid),
      .rsp_assigned_server       (rsp_port.assigned_server),
      .rsp_rejected              (rsp_port.rejected),
      .rsp_finish_time           (rsp_port.finish_time),
      .rsp_server_job_count      (rsp_port.server_job_count),
      .rsp_server_earnings_cents (rsp_port.server_earnings_cents),
      .rsp_latest_finish         (rsp_port.latest_finish)
   );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for shortest_queue_dispatcher_unit: directed and random job words, each
// result word checked field by field against a dispatch predictor kept in the bench.
// Depends on sqd_pkg, the sqd_req_if/sqd_rsp_if/sqd_csr_if interfaces and the unit RTL.
module tb;

   localparam int     ARRIVAL_W     = sqd_pkg::ARRIVAL_W;
   localparam int     SERVICE_W     = sqd_pkg::SERVICE_W;
   localparam int     PAYMENT_W     = sqd_pkg::PAYMENT_W;
   localparam int     ACTIVE_W      = sqd_pkg::ACTIVE_W;
   localparam int     SERVER_W      = sqd_pkg::SERVER_W;
   localparam int     TIME_W        = sqd_pkg::TIME_W;
   localparam int     COUNT_W       = sqd_pkg::COUNT_W;
   localparam int     EARN_W        = sqd_pkg::EARN_W;
   localparam int     NSRV          = sqd_pkg::MAX_SERVERS_DEF;
   localparam int     QDEPTH        = sqd_pkg::QUEUE_DEPTH_DEF;
   localparam longint CYCLE_LIMIT   = 4_000_000;
   localparam int     SETTLE_CYCLES = 300;
   localparam int     RANDOM_JOBS   = 1900;
   localparam int     RANDOM_PHASES = 12;

   // One dispatch result as the unit reports it
   typedef struct packed {
      logic [SERVER_W-1:0] server;
      logic                rejected;
      logic [TIME_W-1:0]   finish;
      logic [COUNT_W-1:0]  job_count;
      logic [EARN_W-1:0]   earned;
      logic [TIME_W-1:0]   latest;
   } dispatch_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sqd_req_if job_ch ();
   sqd_rsp_if result_ch ();
   sqd_csr_if active_ch ();

   shortest_queue_dispatcher_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (job_ch),
      .rsp_port (result_ch),
      .csr_port (active_ch)
   );

   // Predictor state: per-server finish time rings, totals and the active count
   logic [TIME_W-1:0]   fin_q [NSRV][QDEPTH];
   int                  q_head [NSRV];
   int                  q_len [NSRV];
   logic [TIME_W-1:0]   srv_last [NSRV];
   logic [COUNT_W-1:0]  srv_jobs [NSRV];
   logic [EARN_W-1:0]   srv_earned [NSRV];
   logic [TIME_W-1:0]   top_finish;
   logic [ACTIVE_W-1:0] active_cfg;

   dispatch_type awaited_dispatches [$];

   int     jobs_sent     = 0;
   int     words_checked = 0;
   int     rejects_seen  = 0;
   int     cfg_writes    = 0;
   int     error_count   = 0;
   longint cycle_count   = 0;

   bit req_steady     = 1'b0;
   bit rsp_steady     = 1'b0;
   int rsp_stall_left = 0;

   always #4 clock = ~clock;

   // Mostly short idle spans, now and then a long one
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(1, 2);
      if (r < 90)
         return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Dispatch one job: purge expired heads, join the shortest active queue, update totals
   function automatic dispatch_type dispatch_job(input logic [ARRIVAL_W-1:0] arrival,
                                                 input logic [SERVICE_W-1:0] service,
                                                 input logic [PAYMENT_W-1:0] payment);
      dispatch_type      outcome;
      int                drop [NSRV];
      int                n_active, best, best_len, len, k, s;
      logic [TIME_W-1:0] start;
      logic [TIME_W:0]   fin_sum;
      logic [EARN_W:0]   earn_sum;
      outcome  = '0;
      n_active = active_cfg;
      if (n_active < 1)
         n_active = 1;
      if (n_active > NSRV)
         n_active = NSRV;
      best     = 0;
      best_len = 0;
      // count expired entries at each head; ties keep the lowest index
      for (s = 0; s < n_active; s++) begin
         k = 0;
         while (k < q_len[s] && fin_q[s][(q_head[s] + k) % QDEPTH] <= arrival)
            k++;
         drop[s] = k;
         len     = q_len[s] - k;
         if (s == 0 || len < best_len) begin
            best     = s;
            best_len = len;
         end
      end
      if (best_len >= QDEPTH) begin
         // all active queues full: drop the job, touch nothing
         outcome.rejected = 1'b1;
         outcome.latest   = top_finish;
      end else begin
         for (s = 0; s < n_active; s++) begin
            q_head[s] = (q_head[s] + drop[s]) % QDEPTH;
            q_len[s]  = q_len[s] - drop[s];
         end
         start          = (srv_last[best] > arrival) ? srv_last[best] : arrival;
         fin_sum        = {1'b0, start} + service;
         srv_last[best] = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
         fin_q[best][(q_head[best] + q_len[best]) % QDEPTH] = srv_last[best];
         q_len[best]++;
         if (srv_jobs[best] != '1)
            srv_jobs[best]++;
         earn_sum         = {1'b0, srv_earned[best]} + payment;
         srv_earned[best] = earn_sum[EARN_W] ? '1 : earn_sum[EARN_W-1:0];
         if (srv_last[best] > top_finish)
            top_finish = srv_last[best];
         outcome.server    = best[SERVER_W-1:0];
         outcome.finish    = srv_last[best];
         outcome.job_count = srv_jobs[best];
         outcome.earned    = srv_earned[best];
         outcome.latest    = top_finish;
      end
      return outcome;
   endfunction

   function automatic void compare_field(input string what, input longint unsigned want,
                                         input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   // Send one job word after a random gap; predict its result on acceptance
   task automatic send_job(input logic [ARRIVAL_W-1:0] arrival,
                           input logic [SERVICE_W-1:0] service,
                           input logic [PAYMENT_W-1:0] payment);
      int           gap;
      dispatch_type predicted;
      gap = (req_steady || $urandom_range(0, 99) < 45) ? 0 : idle_span();
      @(negedge clock);
      if (gap > 0) begin
         job_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      job_ch.valid         <= 1'b1;
      job_ch.arrival_time  <= arrival;
      job_ch.service_time  <= service;
      job_ch.payment_cents <= payment;
      @(posedge clock);
      while (!job_ch.ready)
         @(posedge clock);
      predicted = dispatch_job(arrival, service, payment);
      awaited_dispatches.insert(awaited_dispatches.size(), predicted);
      jobs_sent++;
   endtask

   // Hold the sender until every outstanding result word has come back
   task automatic drain_results();
      @(negedge clock);
      job_ch.valid <= 1'b0;
      while (awaited_dispatches.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_active(input logic [ACTIVE_W-1:0] value);
      @(negedge clock);
      active_ch.valid <= 1'b1;
      active_ch.data  <= value;
      @(posedge clock);
      while (!active_ch.ready)
         @(posedge clock);
      active_cfg = value;
      cfg_writes++;
      @(negedge clock);
      active_ch.valid <= 1'b0;
   endtask

   // Reset count of eight servers; same arrival spreads jobs over the idle servers
   task automatic test_reset_defaults();
      send_job(32'd0, 16'd10, 24'd100);
      send_job(32'd0, 16'd10, 24'hFF_FFFF);
   endtask

   // One server, sixteen jobs that never expire, then a reject and a purge that frees a slot
   task automatic test_full_queue_reject();
      int i;
      drain_results();
      write_active(4'd1);
      for (i = 0; i < QDEPTH; i++)
         send_job(32'd1000, 16'd5, PAYMENT_W'($urandom_range(0, 24'hFF_FFFF)));
      send_job(32'd1000, 16'd5, 24'd77);
      send_job(32'd1005, 16'd0, 24'd1);
   endtask

   // Zero active count acts as one server; an earlier arrival follows a later one
   task automatic test_active_limits();
      drain_results();
      write_active(4'd0);
      send_job(32'd2000, 16'd0, 24'd3);
      send_job(32'd1500, 16'd7, 24'd4);
      drain_results();
      write_active(4'd15);
      send_job(32'd2100, 16'd3, 24'd5);
   endtask

   // Phases of well-formed rising arrivals, with bursts, late arrivals and pauses mixed in
   task automatic test_random_traffic();
      longint               slice, base, now_tick, arr;
      int                   phase, per_phase, n_eff, svc_cap, step_cap, pick, i;
      logic [ACTIVE_W-1:0]  cfg;
      logic [SERVICE_W-1:0] service;
      logic [PAYMENT_W-1:0] payment;
      slice     = 64'h1_0000_0000 / RANDOM_PHASES;
      per_phase = RANDOM_JOBS / RANDOM_PHASES;
      now_tick  = 3000;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0: cfg = 4'd1;
            1: cfg = 4'd15;
            2: cfg = 4'd0;
            3: cfg = ACTIVE_W'(NSRV);
            default: begin
               if ($urandom_range(0, 99) < 70)
                  cfg = ACTIVE_W'($urandom_range(1, NSRV));
               else
                  cfg = ACTIVE_W'($urandom_range(0, 15));
            end
         endcase
         write_active(cfg);
         n_eff = (cfg == 0) ? 1 : ((cfg > NSRV) ? NSRV : cfg);
         case (phase % 4)
            0: svc_cap = 15;
            1: svc_cap = 255;
            2: svc_cap = 4095;
            default: svc_cap = 65535;
         endcase
         // offered load from twice to half of what the servers can take
         step_cap = (svc_cap * $urandom_range(1, 4)) / (2 * n_eff);
         base     = phase * slice + $urandom_range(0, slice / 4);
         if (base > now_tick)
            now_tick = base;
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         for (i = 0; i < per_phase; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               arr = now_tick - $urandom_range(0, 4 * svc_cap);
               if (arr < 0)
                  arr = 0;
            end else begin
               if (pick >= 12)
                  now_tick = now_tick + $urandom_range(0, step_cap);
               if (now_tick > 64'hFFFF_FFFF)
                  now_tick = 64'hFFFF_FFFF;
               arr = now_tick;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0)
               service = '0;
            else if (pick == 1)
               service = SERVICE_W'(svc_cap);
            else
               service = SERVICE_W'($urandom_range(0, svc_cap));
            pick = $urandom_range(0, 9);
            if (pick == 0)
               payment = '0;
            else if (pick == 1)
               payment = '1;
            else
               payment = PAYMENT_W'($urandom_range(0, 24'hFF_FFFF));
            send_job(arr[31:0], service, payment);
            if ($urandom_range(0, 149) == 0)
               drain_results();
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // Finish time sticks at the top; a late job below it, then a purge at the last tick
   task automatic test_time_saturation();
      drain_results();
      write_active(ACTIVE_W'(NSRV));
      send_job(32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
      send_job(32'hFFFF_FFF0, 16'h0000, 24'h00_0000);
      send_job(32'hFFFF_FFFF, 16'h0000, 24'h00_0000);
   endtask

   // Result side: random stalls on ready, with stretches of none
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         result_ch.ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         result_ch.ready <= 1'b1;
         if (!rsp_steady && $urandom_range(0, 99) < 25)
            rsp_stall_left = idle_span();
      end
   end

   // Check each accepted result word against the oldest prediction
   always @(posedge clock) begin : result_check
      dispatch_type want;
      if (!reset && result_ch.valid && result_ch.ready) begin
         if (awaited_dispatches.size() == 0) begin
            $display("%0t: result word with no job outstanding, expected none, actual server %0d",
                     $time, result_ch.assigned_server);
            error_count++;
         end else begin
            want = awaited_dispatches.pop_front();
            compare_field("assigned_server", want.server, result_ch.assigned_server);
            compare_field("rejected", want.rejected, result_ch.rejected);
            compare_field("finish_time", want.finish, result_ch.finish_time);
            compare_field("server_job_count", want.job_count, result_ch.server_job_count);
            compare_field("server_earnings_cents", want.earned,
                          result_ch.server_earnings_cents);
            compare_field("latest_finish", want.latest, result_ch.latest_finish);
            words_checked++;
            if (want.rejected)
               rejects_seen++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d result words outstanding", $time,
                  awaited_dispatches.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int s, e;
      job_ch.valid         = 1'b0;
      job_ch.arrival_time  = '0;
      job_ch.service_time  = '0;
      job_ch.payment_cents = '0;
      active_ch.valid      = 1'b0;
      active_ch.data       = '0;
      result_ch.ready      = 1'b0;
      for (s = 0; s < NSRV; s++) begin
         q_head[s]     = 0;
         q_len[s]      = 0;
         srv_last[s]   = '0;
         srv_jobs[s]   = '0;
         srv_earned[s] = '0;
         for (e = 0; e < QDEPTH; e++)
            fin_q[s][e] = '0;
      end
      top_finish = '0;
      active_cfg = sqd_pkg::ACTIVE_RESET;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_full_queue_reject();
      test_active_limits();
      test_random_traffic();
      test_time_saturation();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Dispatched %0d jobs over %0d active-count writes; %0d result words checked.",
               jobs_sent, cfg_writes, words_checked);
      $display("Covered %0d full-queue rejects, late arrivals, tie-breaks and time saturation.",
               rejects_seen);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
